// ===== rtl/core/wsrb_pkg.sv =====
`timescale 1ns / 1ps

package wsrb_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 7;
    localparam int TDATA_W  = 128;

    // Command codes on the input tuser
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_STATS = 2'd1;
    localparam logic [1:0] CMD_DUMP  = 2'd2;

    // Result kinds on the output tuser
    localparam logic KIND_STATS = 1'b0;
    localparam logic KIND_ELEM  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;          // write the input sample into the window
        logic clr_scan;    // reset scan pointer and accumulators
        logic init_dump;   // point at the oldest sample
        logic rd;          // read the store at the pointer
        logic step;        // advance pointer and item counter
        logic div_start;   // load the divider from the sum
        logic load_empty;  // load the empty statistics beat
        logic load_stats;  // load the statistics beat
        logic load_elem;   // load one dumped element beat
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;       // window holds no sample
        logic k_last;      // item counter is at the last stored sample
        logic div_done;    // divider finished
        logic out_free;    // output register can take a beat
    } t_dp_sts;

endpackage

// ===== rtl/core/wsrb_dp.sv =====
`timescale 1ns / 1ps

module wsrb_dp #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wsrb_pkg::t_dp_cmd                  i_cmd,
    output wsrb_pkg::t_dp_sts                  o_sts,
    input  logic signed [wsrb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [wsrb_pkg::TDATA_W-1:0]       o_out_data,
    output logic                               o_out_kind,
    output logic                               o_out_last
);

    localparam int SW_ = wsrb_pkg::SAMPLE_W;
    localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW = SW_ + AW + 1;
    localparam int STW = $clog2(SUMW + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);

    // Sample store
    logic signed [SW_-1:0] mem [WINDOW_DEPTH];

    logic [AW-1:0]          r_wslot, n_wslot;
    logic [CW-1:0]          r_fill;
    logic signed [SW_-1:0]  r_newest;
    logic [AW-1:0]          r_ptr, n_ptr_inc;
    logic [CW-1:0]          r_k;
    logic signed [SW_-1:0]  r_rd_data;
    logic                   r_rd_valid;
    logic                   r_first;
    logic signed [SUMW-1:0] r_sum;
    logic signed [SW_-1:0]  r_min, r_max;
    logic [SUMW-1:0]        r_quo;
    logic [CW-1:0]          r_rem;
    logic [STW-1:0]         r_step;
    logic                   r_neg;
    logic                   r_out_valid;
    logic [wsrb_pkg::TDATA_W-1:0] r_out_data;
    logic                   r_out_kind;
    logic                   r_out_last;

    logic                   full;
    logic [SUMW-1:0]        sum_mag;
    logic [CW:0]            div_trial;
    logic                   div_bit;
    logic [SUMW-1:0]        quo_signed;
    logic signed [SUMW-1:0] rd_ext;

    assign full      = (r_fill == FULL_CNT);
    assign n_wslot   = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
    assign n_ptr_inc = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
    assign rd_ext    = {{(SUMW-SW_){r_rd_data[SW_-1]}}, r_rd_data};

    // Status back to the controller
    assign o_sts.empty    = (r_fill == '0);
    assign o_sts.k_last   = (r_k == r_fill - 1'b1);
    assign o_sts.div_done = (r_step == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_wslot] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    // Window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot    <= '0;
            r_fill     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd;
            if (i_cmd.wr) begin
                r_wslot <= n_wslot;
                if (!full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_newest <= i_sample;
        end
    end

    // Scan pointer and item counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_scan) begin
            r_ptr <= '0;
            r_k   <= '0;
        end else if (i_cmd.init_dump) begin
            r_ptr <= full ? r_wslot : '0;
            r_k   <= '0;
        end else if (i_cmd.step) begin
            r_ptr <= n_ptr_inc;
            r_k   <= r_k + 1'b1;
        end
    end

    // Accumulate min, max and sum over read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_scan) begin
            r_first <= 1'b1;
            r_sum   <= '0;
        end else if (r_rd_valid) begin
            r_first <= 1'b0;
            r_sum   <= r_sum + rd_ext;
            if (r_first || (r_rd_data < r_min)) begin
                r_min <= r_rd_data;
            end
            if (r_first || (r_rd_data > r_max)) begin
                r_max <= r_rd_data;
            end
        end
    end

    // Restoring divider on the sum magnitude, one quotient bit per cycle
    assign sum_mag   = r_sum[SUMW-1] ? (~r_sum + 1'b1) : r_sum;
    assign div_trial = {r_rem, r_quo[SUMW-1]};
    assign div_bit   = (div_trial >= {1'b0, r_fill});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.div_start) begin
            r_step <= STW'(SUMW);
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= sum_mag;
            r_rem <= '0;
            r_neg <= r_sum[SUMW-1];
        end else if (r_step != '0) begin
            r_quo <= {r_quo[SUMW-2:0], div_bit};
            r_rem <= div_bit ? CW'(div_trial - {1'b0, r_fill}) : div_trial[CW-1:0];
        end
    end

    assign quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_empty || i_cmd.load_stats || i_cmd.load_elem) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_empty) begin
            r_out_data <= '0;
            r_out_kind <= wsrb_pkg::KIND_STATS;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_stats) begin
            r_out_data <= {{SW_{1'b0}}, quo_signed[SW_-1:0], r_max, r_min, r_newest,
                           wsrb_pkg::COUNT_W'(r_fill), 1'b1};
            r_out_kind <= wsrb_pkg::KIND_STATS;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_elem) begin
            r_out_data <= {r_rd_data, {(4*SW_){1'b0}}, wsrb_pkg::COUNT_W'(r_fill), 1'b1};
            r_out_kind <= wsrb_pkg::KIND_ELEM;
            r_out_last <= o_sts.k_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count above window depth");

    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> (CW'(r_wslot) == r_fill))
        else $error("write slot out of step with fill count");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> (r_rem < r_fill))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/core/wsrb_ctrl.sv =====
`timescale 1ns / 1ps

module wsrb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_in_cmd,
    input  wsrb_pkg::t_dp_sts  i_sts,
    output wsrb_pkg::t_dp_cmd  o_cmd
);

    // Command sequencer states, dump uses a read and a present state per element
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b00000001,
        ST_SCAN     = 8'b00000010,
        ST_SCAN_END = 8'b00000100,
        ST_DIV_LOAD = 8'b00001000,
        ST_DIV      = 8'b00010000,
        ST_STAT_OUT = 8'b00100000,
        ST_DUMP_RD  = 8'b01000000,
        ST_DUMP_OUT = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic   in_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one command at a time
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_cmd)
                        wsrb_pkg::CMD_PUSH: begin
                            o_cmd.wr = 1'b1;
                        end
                        wsrb_pkg::CMD_STATS: begin
                            if (i_sts.empty) begin
                                n_state = ST_STAT_OUT;
                            end else begin
                                o_cmd.clr_scan = 1'b1;
                                n_state        = ST_SCAN;
                            end
                        end
                        wsrb_pkg::CMD_DUMP: begin
                            if (!i_sts.empty) begin
                                o_cmd.init_dump = 1'b1;
                                n_state         = ST_DUMP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.rd   = 1'b1;
                o_cmd.step = 1'b1;
                if (i_sts.k_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_STAT_OUT;
                end
            end
            ST_STAT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_empty = i_sts.empty;
                    o_cmd.load_stats = !i_sts.empty;
                    n_state          = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_elem = 1'b1;
                    if (i_sts.k_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_empty || o_cmd.load_stats || o_cmd.load_elem) |-> i_sts.out_free)
        else $error("output beat loaded over a pending beat");

    a_div_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_LOAD) |=> (r_state == ST_DIV))
        else $error("divider start not followed by divide");
`endif

endmodule

// ===== rtl/core/window_stats_ring_buffer.sv =====
`timescale 1ns / 1ps
// Push: the sample is written into the window, no result. Stats: one store read per
// sample, then a divider that gives one quotient bit per cycle over the sum width
// (24 + clog2(WINDOW_DEPTH) + 1 bits). Dump: a read state and a present state per
// element (single read port, registered read data); the present state waits out any output stall.
// One command is worked at a time; a finished beat waits in the output register.
// Reset is synchronous, active low; the sample store is not cleared.

module window_stats_ring_buffer #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // [23:0] sample
    input  logic [1:0]   s_axis_tuser,   // [1:0] cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] valid_res, [7:1] count, [31:8] newest, [55:32] minimum,
    // [79:56] maximum, [103:80] mean, [127:104] element
    output logic [127:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser,   // [0] kind
    output logic         m_axis_tlast
);

    wsrb_pkg::t_dp_cmd dp_cmd;
    wsrb_pkg::t_dp_sts dp_sts;

    wsrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_cmd   (s_axis_tuser),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    wsrb_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_sample    (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser[0]),
        .o_out_last  (m_axis_tlast)
    );

endmodule
